// ===== src/gnz_pkg.sv =====
package gnz_pkg;

	localparam int FRAC_BITS = 16;
	// fixed-point 1.0 and the constants of fade()
	localparam logic signed [32:0] ONE_FX = 33'sd65536;
	localparam logic signed [32:0] FIFTEEN_FX = 33'sd983040;
	localparam logic signed [32:0] TEN_FX = 33'sd655360;
	localparam logic signed [65:0] HALF_LSB = 66'sd32768;

	// periodic 2D height map: (BASE + L) * height * 40 / (121 << 16)
	localparam logic signed [32:0] HEIGHT_BASE = 33'sd99025;
	localparam logic [63:0] HEIGHT_HALF = 64'd3964928;
	// x / 121: estimate with floor(2^38 / 121) on x >> 12 (shift 26), then the
	// small remainder goes through ceil(2^21 / 121) (shift 21)
	localparam logic [31:0] HEIGHT_RCP = 32'd2271718239;
	localparam logic [15:0] HEIGHT_RCP_LO = 16'd17332;

	localparam int DIV_W = 48;

	localparam logic [3:0] OP_TABLE = 4'd0;
	localparam logic [3:0] OP_LAST_PLAIN = 4'd4;
	localparam logic [3:0] OP_LAST = 4'd8;

	localparam logic [2:0] REG_PERIOD_X = 3'd0;
	localparam logic [2:0] REG_PERIOD_Y = 3'd1;
	localparam logic [2:0] REG_PERIOD_Z = 3'd2;
	localparam logic [2:0] REG_PERIOD_W = 3'd3;
	localparam logic [2:0] REG_HEIGHT = 3'd4;

	typedef enum logic [4:0] {
		S_IDLE, S_AXIS, S_DIV, S_IDX,
		S_F1, S_F2, S_F3, S_F4, S_F5,
		S_LOOK, S_GRAD,
		S_LA, S_LB, S_LD, S_LM, S_LW,
		S_FIN, S_FM, S_FS, S_FH, S_FH2,
		S_HQ, S_HR, S_HM, S_HC, S_HEND, S_OUT
	} state_t;

	// Q0.16 output scale per dimension
	function automatic logic signed [32:0] scale_k(input logic [2:0] dims);
		logic signed [32:0] k;
		begin
			unique case (dims)
				3'd1: k = 33'sd12321;
				3'd2: k = 33'sd33227;
				3'd3: k = 33'sd61342;
				3'd4: k = 33'sd57016;
				default: k = 33'sd0;
			endcase
			return k;
		end
	endfunction

endpackage

// ===== src/gradient_noise_1d_to_4d.sv =====
// Channel | Dir | Fields (tdata/tuser, low bit first)
// s_*     | in  | tuser: opcode[3:0]; tdata: coord_x, coord_y, coord_z, coord_w,
//         |     |        table_index, table_value (144 bits)
// m_*     | out | tdata: noise_value[31:0]
// cfg_*   | in  | cfg_index 0..4 = period_x, period_y, period_z, period_w, out_height
//
// One item at a time through a single shared 33x33 multiplier; period remainders use a
// one-bit-per-cycle divider, the height map divides by 121 with reciprocal multiplies.
// Per axis: setup of both cell sides, then fade steps S_F1..S_F5; in periodic modes each
// side with a nonzero period also runs the divider. Per corner: dims table reads plus a
// gradient step; each lerp runs S_LA, S_LB, S_LD, S_LM, S_LW; then the finish states. The
// periodic 2D height map adds S_FH to S_HEND. arst_n resets control, every period to 256
// and the height to 65536; the permutation table must be loaded first.
// s_tready is high only in idle; the next item is taken while a word waits on m_*.
module gradient_noise_1d_to_4d (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [143:0] s_tdata,  // coord_x, coord_y, coord_z, coord_w, table_index, table_value
	input  logic [3:0]   s_tuser,  // opcode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata,  // noise_value
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [30:0]  cfg_wdata
);

	gnz_pkg::state_t state_q, state_d;

	logic [15:0] period_q [4];
	logic [30:0] height_q;

	logic [2:0]  dims_q;
	logic        per_q;
	logic [31:0] coord_q [4];
	logic [1:0]  k_q;
	logic        side_q;
	logic [15:0] fr_q [4];
	logic [7:0]  idx_q [4][2];
	logic [17:0] fd_q [4];

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_q, rsv;
	logic signed [32:0] tmp_q;

	logic [gnz_pkg::DIV_W-1:0] div_num_q;
	logic [15:0] div_rem_q, div_den_q;
	logic [5:0]  div_cnt_q;
	logic        div_neg_q;
	logic [16:0] dtry;
	logic        dge;

	logic [7:0]  perm_mem [256];
	logic [7:0]  rd_q;
	logic [3:0]  c_q;
	logic [1:0]  lk_q;
	logic        first_q;

	logic signed [23:0] val_mem [16];
	logic signed [23:0] vrd_q, a_q;
	logic signed [24:0] diff_q;
	logic [2:0]  j_q;
	logic [3:0]  half;

	logic signed [63:0] hp_q;
	logic [31:0] res_q;
	logic        out_valid_q;
	logic [31:0] out_data_q;

	logic signed [16:0] cell_s;
	logic [16:0] cell_mag;
	logic        wrap;
	logic [3:0]  last_c;
	logic        hmode;
	logic signed [32:0] t_fx;
	logic [7:0]  look_addr;
	logic signed [17:0] p [4];
	logic signed [23:0] pe [4];
	logic signed [23:0] grad;
	logic [4:0]  h;
	logic signed [23:0] gu, gv, gw;
	logic [3:0]  g1;
	logic signed [63:0] hmag;
	logic [63:0] m2;
	logic [47:0] q_h;
	logic [47:0] q121;

	assign s_tready = (state_q == gnz_pkg::S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	assign cell_s = side_q ? {coord_q[k_q][31], coord_q[k_q][31:16]} + 17'sd1
	                       : {coord_q[k_q][31], coord_q[k_q][31:16]};
	assign cell_mag = cell_s[16] ? 17'(-cell_s) : cell_s;
	assign wrap = per_q && (period_q[k_q] != 16'd0);
	assign last_c = 4'((5'd1 << dims_q) - 5'd1);
	assign hmode = per_q && (dims_q == 3'd2);
	assign t_fx = {17'd0, fr_q[k_q]};
	assign rsv = (prod_q + gnz_pkg::HALF_LSB) >>> gnz_pkg::FRAC_BITS;
	assign half = 4'(4'd1 << lk_q);
	assign look_addr = idx_q[lk_q][c_q[lk_q]] + (first_q ? 8'd0 : rd_q);

	assign dtry = {div_rem_q, div_num_q[gnz_pkg::DIV_W-1]};
	assign dge = dtry >= {1'b0, div_den_q};

	assign hmag = hp_q[63] ? -hp_q : hp_q;
	assign m2 = (64'(hmag) + gnz_pkg::HEIGHT_HALF) >> gnz_pkg::FRAC_BITS;
	// quotient estimate, never above the true quotient
	assign q_h = hp_q[47:0];
	assign q121 = (q_h << 7) - (q_h << 3) + q_h;

	// gradient of the current corner; h is the low five bits of the last table byte
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			p[i] = c_q[i] ? $signed({2'b11, fr_q[i]}) : $signed({2'b00, fr_q[i]});
			pe[i] = {{6{p[i][17]}}, p[i]};
		end
		h = rd_q[4:0];
		g1 = 4'd1 + {1'b0, h[2:0]};
		gu = pe[0];
		gv = pe[1];
		gw = pe[2];
		grad = '0;
		unique case (dims_q)
			3'd1: begin
				grad = 24'(pe[0] * $signed({2'b00, g1}));
				if (h[3]) grad = -grad;
			end
			3'd2: begin
				gu = (h[2:0] < 3'd4) ? pe[0] : pe[1];
				gv = (h[2:0] < 3'd4) ? pe[1] : pe[0];
				grad = (h[0] ? -gu : gu) + (h[1] ? -(gv <<< 1) : (gv <<< 1));
			end
			3'd3: begin
				gu = (h[3:0] < 4'd8) ? pe[0] : pe[1];
				gv = (h[3:0] < 4'd4) ? pe[1] :
				     ((h[3:0] == 4'd12) || (h[3:0] == 4'd14)) ? pe[0] : pe[2];
				grad = (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
			end
			default: begin
				gu = (h < 5'd24) ? pe[0] : pe[1];
				gv = (h < 5'd16) ? pe[1] : pe[2];
				gw = (h < 5'd8) ? pe[2] : pe[3];
				grad = (h[0] ? -gu : gu) + (h[1] ? -gv : gv) + (h[2] ? -gw : gw);
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gnz_pkg::S_IDLE:
				if (s_tvalid && (s_tuser != gnz_pkg::OP_TABLE) && (s_tuser <= gnz_pkg::OP_LAST))
					state_d = gnz_pkg::S_AXIS;
			gnz_pkg::S_AXIS:
				state_d = wrap ? gnz_pkg::S_DIV : (side_q ? gnz_pkg::S_F1 : gnz_pkg::S_AXIS);
			gnz_pkg::S_DIV:
				if (div_cnt_q == 6'd1)
					state_d = gnz_pkg::S_IDX;
			gnz_pkg::S_IDX: state_d = side_q ? gnz_pkg::S_F1 : gnz_pkg::S_AXIS;
			gnz_pkg::S_F1: state_d = gnz_pkg::S_F2;
			gnz_pkg::S_F2: state_d = gnz_pkg::S_F3;
			gnz_pkg::S_F3: state_d = gnz_pkg::S_F4;
			gnz_pkg::S_F4: state_d = gnz_pkg::S_F5;
			gnz_pkg::S_F5:
				state_d = ({1'b0, k_q} == dims_q - 3'd1) ? gnz_pkg::S_LOOK : gnz_pkg::S_AXIS;
			gnz_pkg::S_LOOK: if (lk_q == 2'd0) state_d = gnz_pkg::S_GRAD;
			gnz_pkg::S_GRAD: state_d = (c_q == last_c) ? gnz_pkg::S_LA : gnz_pkg::S_LOOK;
			gnz_pkg::S_LA: state_d = gnz_pkg::S_LB;
			gnz_pkg::S_LB: state_d = gnz_pkg::S_LD;
			gnz_pkg::S_LD: state_d = gnz_pkg::S_LM;
			gnz_pkg::S_LM: state_d = gnz_pkg::S_LW;
			gnz_pkg::S_LW:
				if (({1'b0, j_q} == half - 4'd1) && (lk_q == 2'd0))
					state_d = gnz_pkg::S_FIN;
				else
					state_d = gnz_pkg::S_LA;
			gnz_pkg::S_FIN: state_d = gnz_pkg::S_FM;
			gnz_pkg::S_FM: state_d = hmode ? gnz_pkg::S_FH : gnz_pkg::S_FS;
			gnz_pkg::S_FS: state_d = gnz_pkg::S_OUT;
			gnz_pkg::S_FH: state_d = gnz_pkg::S_FH2;
			gnz_pkg::S_FH2: state_d = gnz_pkg::S_HQ;
			gnz_pkg::S_HQ: state_d = gnz_pkg::S_HR;
			gnz_pkg::S_HR: state_d = gnz_pkg::S_HM;
			gnz_pkg::S_HM: state_d = gnz_pkg::S_HC;
			gnz_pkg::S_HC: state_d = gnz_pkg::S_HEND;
			gnz_pkg::S_HEND: state_d = gnz_pkg::S_OUT;
			gnz_pkg::S_OUT: if (!out_valid_q || m_tready) state_d = gnz_pkg::S_IDLE;
			default: state_d = gnz_pkg::S_IDLE;
		endcase
	end

	// multiplier operand select
	always_comb begin
		mul_a = t_fx;
		mul_b = t_fx;
		unique case (state_q)
			gnz_pkg::S_F2: mul_a = rsv[32:0];
			gnz_pkg::S_F3: mul_b = 33'(t_fx * 33'sd6) - gnz_pkg::FIFTEEN_FX;
			gnz_pkg::S_F4: begin
				mul_a = tmp_q;
				mul_b = rsv[32:0] + gnz_pkg::TEN_FX;
			end
			gnz_pkg::S_LM: begin
				mul_a = {15'd0, fd_q[lk_q]};
				mul_b = {{8{diff_q[24]}}, diff_q};
			end
			gnz_pkg::S_FM: begin
				if (hmode) begin
					mul_a = {{9{vrd_q[23]}}, vrd_q} + gnz_pkg::HEIGHT_BASE;
					mul_b = {2'b00, height_q};
				end else begin
					mul_a = {{9{vrd_q[23]}}, vrd_q};
					mul_b = gnz_pkg::scale_k(dims_q);
				end
			end
			gnz_pkg::S_FH2: begin
				mul_a = {1'b0, m2[43:12]};
				mul_b = {1'b0, gnz_pkg::HEIGHT_RCP};
			end
			gnz_pkg::S_HM: begin
				mul_a = {17'd0, div_rem_q};
				mul_b = {17'd0, gnz_pkg::HEIGHT_RCP_LO};
			end
			default: begin
				mul_a = t_fx;
				mul_b = t_fx;
			end
		endcase
	end

	// control and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gnz_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 4; i++) period_q[i] <= 16'd256;
			height_q <= 31'd65536;
			k_q <= '0;
			side_q <= 1'b0;
			div_cnt_q <= '0;
			c_q <= '0;
			lk_q <= '0;
			first_q <= 1'b0;
			j_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					gnz_pkg::REG_PERIOD_X: period_q[0] <= cfg_wdata[15:0];
					gnz_pkg::REG_PERIOD_Y: period_q[1] <= cfg_wdata[15:0];
					gnz_pkg::REG_PERIOD_Z: period_q[2] <= cfg_wdata[15:0];
					gnz_pkg::REG_PERIOD_W: period_q[3] <= cfg_wdata[15:0];
					gnz_pkg::REG_HEIGHT: height_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (state_q == gnz_pkg::S_OUT && (!out_valid_q || m_tready))
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				gnz_pkg::S_IDLE: begin
					k_q <= '0;
					side_q <= 1'b0;
				end
				gnz_pkg::S_AXIS: begin
					if (wrap) begin
						div_cnt_q <= 6'd17;
					end else begin
						side_q <= ~side_q;
					end
				end
				gnz_pkg::S_DIV: div_cnt_q <= div_cnt_q - 6'd1;
				gnz_pkg::S_IDX: side_q <= ~side_q;
				gnz_pkg::S_F5: begin
					k_q <= k_q + 2'd1;
					side_q <= 1'b0;
					c_q <= '0;
					lk_q <= 2'(dims_q - 3'd1);
					first_q <= 1'b1;
				end
				gnz_pkg::S_LOOK: begin
					first_q <= 1'b0;
					if (lk_q != 2'd0) lk_q <= lk_q - 2'd1;
				end
				gnz_pkg::S_GRAD: begin
					c_q <= c_q + 4'd1;
					lk_q <= 2'(dims_q - 3'd1);
					first_q <= 1'b1;
					j_q <= '0;
				end
				gnz_pkg::S_LW: begin
					if ({1'b0, j_q} == half - 4'd1) begin
						j_q <= '0;
						if (lk_q != 2'd0) lk_q <= lk_q - 2'd1;
					end else begin
						j_q <= j_q + 3'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			gnz_pkg::S_IDLE: begin
				dims_q <= (s_tuser > gnz_pkg::OP_LAST_PLAIN) ? 3'(s_tuser - 4'd4) : s_tuser[2:0];
				per_q <= s_tuser > gnz_pkg::OP_LAST_PLAIN;
				for (int i = 0; i < 4; i++) coord_q[i] <= s_tdata[32*i +: 32];
			end
			gnz_pkg::S_AXIS: begin
				fr_q[k_q] <= coord_q[k_q][15:0];
				if (wrap) begin
					div_num_q <= {cell_mag, 31'd0};
					div_rem_q <= '0;
					div_den_q <= period_q[k_q];
					div_neg_q <= cell_s[16];
				end else begin
					idx_q[k_q][side_q] <= cell_s[7:0];
				end
			end
			gnz_pkg::S_DIV: begin
				div_num_q <= {div_num_q[gnz_pkg::DIV_W-2:0], dge};
				div_rem_q <= dge ? 16'(dtry - {1'b0, div_den_q}) : dtry[15:0];
			end
			gnz_pkg::S_IDX:
				idx_q[k_q][side_q] <= div_neg_q ? 8'(-div_rem_q[7:0]) : div_rem_q[7:0];
			gnz_pkg::S_F3: tmp_q <= rsv[32:0];
			gnz_pkg::S_F5: fd_q[k_q] <= rsv[17:0];
			gnz_pkg::S_LA: vrd_q <= val_mem[{1'b0, j_q}];
			gnz_pkg::S_LB: begin
				a_q <= vrd_q;
				vrd_q <= val_mem[{1'b0, j_q} + half];
			end
			gnz_pkg::S_LD: diff_q <= {vrd_q[23], vrd_q} - {a_q[23], a_q};
			gnz_pkg::S_FIN: vrd_q <= val_mem[0];
			gnz_pkg::S_FS: begin
				if (rsv > 66'sd2147483647) res_q <= 32'h7fff_ffff;
				else if (rsv < -66'sd2147483648) res_q <= 32'h8000_0000;
				else res_q <= rsv[31:0];
			end
			gnz_pkg::S_FH: hp_q <= 64'(prod_q <<< 5) + 64'(prod_q <<< 3);
			gnz_pkg::S_FH2: begin
				div_num_q <= m2[47:0];
				div_neg_q <= hp_q[63];
			end
			// estimate is at most 48 below the quotient
			gnz_pkg::S_HQ: hp_q <= {26'd0, prod_q[63:26]};
			gnz_pkg::S_HR: div_rem_q <= 16'(div_num_q - q121);
			gnz_pkg::S_HC: hp_q <= hp_q + {53'd0, prod_q[31:21]};
			gnz_pkg::S_HEND: begin
				if (!div_neg_q && (q_h > 48'd2147483647)) res_q <= 32'h7fff_ffff;
				else if (div_neg_q && (q_h > 48'd2147483648)) res_q <= 32'h8000_0000;
				else res_q <= div_neg_q ? 32'(-q_h) : q_h[31:0];
			end
			gnz_pkg::S_OUT:
				if (!out_valid_q || m_tready) out_data_q <= res_q;
			default: ;
		endcase
	end

	// permutation table and corner values
	always_ff @(posedge clk) begin
		if (state_q == gnz_pkg::S_IDLE && s_tvalid && s_tuser == gnz_pkg::OP_TABLE)
			perm_mem[s_tdata[135:128]] <= s_tdata[143:136];
		if (state_q == gnz_pkg::S_LOOK)
			rd_q <= perm_mem[look_addr];
		if (state_q == gnz_pkg::S_GRAD)
			val_mem[c_q] <= grad;
		else if (state_q == gnz_pkg::S_LW)
			val_mem[{1'b0, j_q}] <= a_q + rsv[23:0];
	end

`ifndef SYNTHESIS
	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gnz_pkg::S_DIV) |-> (div_cnt_q != 6'd0))
		else $error("divider running with zero count");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gnz_pkg::S_OUT && out_valid_q && !m_tready) |=> (state_q == gnz_pkg::S_OUT))
		else $error("pending word overwritten");
	a_lerp_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gnz_pkg::S_LW) |-> ({1'b0, j_q} < half))
		else $error("lerp index past half");
`endif

endmodule
